FILE: sv/four_function_key_calculator_defines.svh
// Assertion shorthands shared by the calculator RTL
`ifndef FOUR_FUNCTION_KEY_CALCULATOR_DEFINES_SVH
`define FOUR_FUNCTION_KEY_CALCULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FKC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calculator assertion failed");

// Next-cycle implication, checked outside reset
`define FKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calculator assertion failed");

`endif

FILE: sv/fkc_pkg.sv
package fkc_pkg;

   // Default datapath width
   localparam int unsigned VALUE_WIDTH_DEFAULT = 32;
   localparam int unsigned SHOWN_WIDTH         = 32;
   localparam int unsigned OPCODE_WIDTH        = 3;
   localparam int unsigned DIGIT_WIDTH         = 4;

   // Key codes; pending operation reuses the operator codes
   localparam logic [OPCODE_WIDTH-1:0] OP_DIGIT     = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_ADD       = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_SUB       = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_MUL       = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_DIV       = 3'd4;
   localparam logic [OPCODE_WIDTH-1:0] OP_EQUALS    = 3'd5;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR     = 3'd6;
   localparam logic [OPCODE_WIDTH-1:0] OP_BACKSPACE = 3'd7;
   localparam logic [OPCODE_WIDTH-1:0] PEND_NONE    = 3'd0;

   // Entry limits
   localparam int unsigned DIGIT_CAP = 99999999;
   localparam int unsigned RADIX     = 10;
   localparam logic [DIGIT_WIDTH-1:0] MAX_DIGIT = 4'd9;

   // Request to the shared multiply/divide unit
   typedef struct packed {
      logic start;
      logic div;
   } mdu_req_type;

endpackage

FILE: sv/fkc_mdu.sv
`include "four_function_key_calculator_defines.svh"

module fkc_mdu #(
   parameter int unsigned VALUE_WIDTH = fkc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fkc_pkg::mdu_req_type    req,
   input  logic [VALUE_WIDTH-1:0]  opa,
   input  logic [VALUE_WIDTH-1:0]  opb,
   output logic                    done,
   output logic [VALUE_WIDTH-1:0]  result
);
   import fkc_pkg::*;

   localparam int unsigned W     = VALUE_WIDTH;
   localparam int unsigned STEPS = W + 1;
   localparam int unsigned CNT_W = $clog2(STEPS + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             div_ff, div_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     lo_ff, lo_in;
   logic [W-1:0]     hi_ff, hi_in;
   logic [W-1:0]     opnd_ff, opnd_in;

   logic [W-1:0]     mag_a, mag_b;
   logic [W:0]       rem_sh;
   logic [W:0]       add_x, add_y, sum;
   logic             add_cin;
   logic             last_step;

   // Operand magnitudes for the divider
   assign mag_a = opa[W-1] ? (~opa + W'(1)) : opa;
   assign mag_b = opb[W-1] ? (~opb + W'(1)) : opb;

   assign rem_sh    = {hi_ff, lo_ff[W-1]};
   assign last_step = (cnt_ff == CNT_W'(1));

   // Select operands of the one shared adder
   always_comb begin
      add_x   = {1'b0, hi_ff};
      add_y   = {1'b0, opnd_ff};
      add_cin = 1'b0;
      if (last_step) begin
         add_x   = {1'b0, ~lo_ff};
         add_y   = '0;
         add_cin = 1'b1;
      end else if (div_ff) begin
         add_x   = rem_sh;
         add_y   = ~{1'b0, opnd_ff};
         add_cin = 1'b1;
      end
   end

   assign sum = add_x + add_y + (W + 1)'(add_cin);

   // Load, iterate one bit a step, then fix the quotient sign
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      opnd_in = opnd_ff;
      if (req.start) begin
         busy_in = 1'b1;
         div_in  = req.div;
         neg_in  = opa[W-1] ^ opb[W-1];
         cnt_in  = CNT_W'(STEPS);
         hi_in   = '0;
         if (req.div) begin
            lo_in   = mag_a;
            opnd_in = mag_b;
         end else begin
            lo_in   = opb;
            opnd_in = opa;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (div_ff && neg_ff) begin
               lo_in = sum[W-1:0];
            end
         end else if (div_ff) begin
            if (sum[W]) begin
               hi_in = rem_sh[W-1:0];
               lo_in = {lo_ff[W-2:0], 1'b0};
            end else begin
               hi_in = sum[W-1:0];
               lo_in = {lo_ff[W-2:0], 1'b1};
            end
         end else begin
            if (lo_ff[0]) begin
               hi_in = sum[W-1:0];
            end
            lo_in   = lo_ff >> 1;
            opnd_in = opnd_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      opnd_ff <= opnd_in;
   end

   assign done   = done_ff;
   assign result = div_ff ? lo_ff : hi_ff;

   `FKC_ASSERT_IMPLIES(a_start_when_free, clock, reset, req.start, !busy_ff)
   `FKC_ASSERT_NEXT(a_start_loads, clock, reset, req.start, busy_ff && cnt_ff == CNT_W'(STEPS))
   `FKC_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff && !busy_ff)

endmodule

FILE: sv/four_function_key_calculator.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------
// req      | req_valid / req_stall | req_opcode[2:0], req_digit[3:0]
// rsp      | rsp_valid / rsp_stall | rsp_shown_value[31:0] signed, rsp_error
//
// Keys that need no multiply or divide finish in the accept cycle; the item is
// out in the next cycle.
// An operator or equals key over a pending multiply or divide by a non-zero
// entry, and backspace on a live entry, use the shared shift/add unit for
// VALUE_WIDTH + 1 steps, input held off while they run.
// Synchronous reset clears the calculator; a stalled result holds the input off.
`include "four_function_key_calculator_defines.svh"

module four_function_key_calculator #(
   parameter int unsigned VALUE_WIDTH = fkc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [fkc_pkg::OPCODE_WIDTH-1:0]       req_opcode,
   input  logic [fkc_pkg::DIGIT_WIDTH-1:0]        req_digit,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [fkc_pkg::SHOWN_WIDTH-1:0] rsp_shown_value,
   output logic                                   rsp_error
);
   import fkc_pkg::*;

   localparam int unsigned W     = VALUE_WIDTH;
   localparam int unsigned CAP_W = $clog2(DIGIT_CAP + 1);
   localparam int unsigned MAG_W = (W > CAP_W) ? W : CAP_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WAIT = 1'b1;

   logic                    state_ff, state_in;
   logic [W-1:0]            entry_ff, entry_in;
   logic [W-1:0]            acc_ff, acc_in;
   logic [OPCODE_WIDTH-1:0] pend_ff, pend_in;
   logic                    fresh_ff, fresh_in;
   logic                    err_ff, err_in;
   logic [W-1:0]            disp_ff, disp_in;
   logic [OPCODE_WIDTH-1:0] key_ff, key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SHOWN_WIDTH-1:0]  rsp_shown_ff, rsp_shown_in;
   logic                    rsp_error_ff, rsp_error_in;

   logic                    accept;
   logic                    ignored;
   logic                    clear_first;
   logic [W-1:0]            eff_entry, eff_acc;
   logic [OPCODE_WIDTH-1:0] eff_pend;
   logic                    eff_fresh;
   logic [W-1:0]            eff_mag;
   logic [W-1:0]            dig_w;
   logic [W-1:0]            times_ten, appended;
   logic                    is_sub;
   logic [W-1:0]            addsub;
   logic                    rsp_load;
   logic                    fin_go;
   logic [OPCODE_WIDTH-1:0] fin_key;
   logic [W-1:0]            fin_val;

   mdu_req_type             mdu_req;
   logic [W-1:0]            mdu_a, mdu_b;
   logic                    mdu_done;
   logic [W-1:0]            mdu_result;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Key classification and state as seen after an error clear
   assign ignored     = (req_opcode == OP_DIGIT) && (req_digit > MAX_DIGIT);
   assign clear_first = err_ff && (req_opcode != OP_BACKSPACE) && !ignored;
   assign eff_entry   = clear_first ? '0 : entry_ff;
   assign eff_acc     = clear_first ? '0 : acc_ff;
   assign eff_pend    = clear_first ? PEND_NONE : pend_ff;
   assign eff_fresh   = clear_first ? 1'b1 : fresh_ff;

   // Digit append: entry * 10 plus or minus the digit
   assign eff_mag   = eff_entry[W-1] ? (~eff_entry + W'(1)) : eff_entry;
   assign dig_w     = W'(req_digit);
   assign times_ten = (eff_entry << 3) + (eff_entry << 1);
   assign appended  = eff_entry[W-1] ? (times_ten - dig_w) : (times_ten + dig_w);

   // Add or subtract of a pending operation
   assign is_sub = (eff_pend == OP_SUB);
   assign addsub = eff_acc + (is_sub ? ~eff_entry : eff_entry) + W'(is_sub);

   // Sequence one key
   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      fresh_in = fresh_ff;
      err_in   = err_ff;
      disp_in  = disp_ff;
      key_in   = key_ff;
      rsp_load = 1'b0;
      fin_go   = 1'b0;
      fin_key  = req_opcode;
      fin_val  = eff_entry;
      mdu_req  = '0;
      mdu_a    = eff_acc;
      mdu_b    = eff_entry;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (ignored) begin
                  rsp_load = 1'b1;
               end else if (req_opcode == OP_BACKSPACE) begin
                  if (fresh_ff) begin
                     rsp_load = 1'b1;
                  end else begin
                     mdu_req.start = 1'b1;
                     mdu_req.div   = 1'b1;
                     mdu_a         = entry_ff;
                     mdu_b         = W'(RADIX);
                     key_in        = req_opcode;
                     state_in      = ST_WAIT;
                  end
               end else begin
                  entry_in = eff_entry;
                  acc_in   = eff_acc;
                  pend_in  = eff_pend;
                  fresh_in = eff_fresh;
                  err_in   = 1'b0;
                  if (clear_first) begin
                     disp_in = '0;
                  end
                  if (req_opcode == OP_DIGIT) begin
                     if (eff_fresh) begin
                        entry_in = dig_w;
                        fresh_in = 1'b0;
                     end else if (MAG_W'(eff_mag) <= MAG_W'(DIGIT_CAP)) begin
                        entry_in = appended;
                     end
                     disp_in  = entry_in;
                     rsp_load = 1'b1;
                  end else if (req_opcode == OP_CLEAR) begin
                     entry_in = '0;
                     acc_in   = '0;
                     pend_in  = PEND_NONE;
                     fresh_in = 1'b1;
                     disp_in  = '0;
                     rsp_load = 1'b1;
                  end else begin
                     case (eff_pend)
                        OP_ADD, OP_SUB: begin
                           fin_go  = 1'b1;
                           fin_val = addsub;
                        end
                        OP_MUL: begin
                           mdu_req.start = 1'b1;
                           key_in        = req_opcode;
                           state_in      = ST_WAIT;
                        end
                        OP_DIV: begin
                           if (eff_entry == '0) begin
                              // divide by zero: raise the error
                              entry_in = '0;
                              acc_in   = '0;
                              pend_in  = PEND_NONE;
                              fresh_in = 1'b1;
                              err_in   = 1'b1;
                              disp_in  = '0;
                              rsp_load = 1'b1;
                           end else begin
                              mdu_req.start = 1'b1;
                              mdu_req.div   = 1'b1;
                              key_in        = req_opcode;
                              state_in      = ST_WAIT;
                           end
                        end
                        default: begin
                           fin_go  = 1'b1;
                           fin_val = eff_entry;
                        end
                     endcase
                  end
               end
            end
         end
         ST_WAIT: begin
            if (mdu_done) begin
               state_in = ST_IDLE;
               if (key_ff == OP_BACKSPACE) begin
                  entry_in = mdu_result;
                  fresh_in = (mdu_result == '0);
                  disp_in  = mdu_result;
                  rsp_load = 1'b1;
               end else begin
                  fin_go  = 1'b1;
                  fin_key = key_ff;
                  fin_val = mdu_result;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Finish an operator or equals key with the new accumulator
      if (fin_go) begin
         acc_in = fin_val;
         if (fin_key == OP_EQUALS) begin
            entry_in = fin_val;
            pend_in  = PEND_NONE;
         end else begin
            pend_in = fin_key;
         end
         fresh_in = 1'b1;
         disp_in  = fin_val;
         rsp_load = 1'b1;
      end
   end

   // Output register: load a new item or drop the taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_shown_in = rsp_shown_ff;
      rsp_error_in = rsp_error_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_shown_in = err_in ? '0 : SHOWN_WIDTH'(signed'(disp_in));
         rsp_error_in = err_in;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entry_ff     <= '0;
         acc_ff       <= '0;
         pend_ff      <= PEND_NONE;
         fresh_ff     <= 1'b1;
         err_ff       <= 1'b0;
         disp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_ff     <= entry_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         fresh_ff     <= fresh_in;
         err_ff       <= err_in;
         disp_ff      <= disp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      rsp_shown_ff <= rsp_shown_in;
      rsp_error_ff <= rsp_error_in;
   end

   fkc_mdu #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .req    (mdu_req),
      .opa    (mdu_a),
      .opb    (mdu_b),
      .done   (mdu_done),
      .result (mdu_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shown_value = rsp_shown_ff;
   assign rsp_error       = rsp_error_ff;

   `FKC_ASSERT_IMPLIES(a_done_in_wait, clock, reset, mdu_done, state_ff == ST_WAIT)
   `FKC_ASSERT_IMPLIES(a_wait_out_empty, clock, reset, state_ff == ST_WAIT, !rsp_valid_ff)
   `FKC_ASSERT_IMPLIES(a_error_shows_zero, clock, reset, rsp_valid_ff && rsp_error_ff, rsp_shown_ff == '0)
   `FKC_ASSERT_IMPLIES(a_error_state_clear, clock, reset, err_ff, fresh_ff && entry_ff == '0 && acc_ff == '0)

endmodule
